// ----- rtl/tot_pkg.sv -----
`timescale 1ns / 1ps

package tot_pkg;

   localparam int ENTRIES  = 64;
   localparam int IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W    = $clog2(ENTRIES + 1);
   localparam int HALF_W   = 64;
   localparam int KEY_W    = 2 * HALF_W;
   localparam int NODE_W   = 7;
   localparam int OP_W     = 2;
   localparam int STATUS_W = 3;
   localparam int TOKEN_W  = 7;

   typedef enum logic [OP_W-1:0] {
      OP_ACQUIRE = 2'd0,
      OP_QUERY   = 2'd1,
      OP_RELEASE = 2'd2,
      OP_FORCE   = 2'd3
   } tot_op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 3'd0,
      ST_FULL      = 3'd1,
      ST_OTHER     = 3'd2,
      ST_NOTOKEN   = 3'd3,
      ST_NOTHOLDER = 3'd4,
      ST_INVALID   = 3'd5
   } tot_status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_DECIDE,
      S_RESP
   } tot_state_type;

   // Write command from the sequencer to the table store.
   typedef struct packed {
      logic              en;
      logic [IDX_W-1:0]  addr;
      logic [KEY_W-1:0]  key;
      logic [NODE_W-1:0] holder;
      logic              live;
   } tot_wr_type;

   // Outcome of one pass over the table.
   typedef struct packed {
      logic              hit;
      logic [IDX_W-1:0]  hit_idx;
      logic [NODE_W-1:0] hit_holder;
      logic              free_found;
      logic [IDX_W-1:0]  free_idx;
   } tot_scan_type;

endpackage

// ----- rtl/tot_if.sv -----
`timescale 1ns / 1ps

interface tot_req_if;
   logic                         valid;
   logic                         ready;
   logic [tot_pkg::OP_W-1:0]     operation;
   logic [tot_pkg::HALF_W-1:0]   key_high;
   logic [tot_pkg::HALF_W-1:0]   key_low;
   logic [tot_pkg::NODE_W-1:0]   node_id;

   modport source (output valid, operation, key_high, key_low, node_id, input ready);
   modport sink (input valid, operation, key_high, key_low, node_id, output ready);
endinterface

interface tot_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [tot_pkg::STATUS_W-1:0] status;
   logic [tot_pkg::NODE_W-1:0]   holder;
   logic [tot_pkg::TOKEN_W-1:0]  token_count;

   modport source (output valid, status, holder, token_count, input ready);
   modport sink (input valid, status, holder, token_count, output ready);
endinterface

// ----- rtl/tot_store.sv -----
`timescale 1ns / 1ps

module tot_store (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [tot_pkg::IDX_W-1:0]  rd_addr,
   input  tot_pkg::tot_wr_type        wr,
   output logic [tot_pkg::KEY_W-1:0]  rd_key_ff,
   output logic [tot_pkg::NODE_W-1:0] rd_holder_ff,
   output logic                       rd_live_ff
);
   import tot_pkg::*;

   logic [KEY_W-1:0]   key_mem    [ENTRIES];
   logic [NODE_W-1:0]  holder_mem [ENTRIES];
   logic [ENTRIES-1:0] live_ff;

   // Key and holder storage; a slot without its live bit reads as free.
   always_ff @(posedge clock) begin
      if (wr.en) begin
         key_mem[wr.addr]    <= wr.key;
         holder_mem[wr.addr] <= wr.holder;
      end
      rd_key_ff    <= key_mem[rd_addr];
      rd_holder_ff <= holder_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         live_ff    <= '0;
         rd_live_ff <= 1'b0;
      end else begin
         if (wr.en) begin
            live_ff[wr.addr] <= wr.live;
         end
         rd_live_ff <= live_ff[rd_addr];
      end
   end

endmodule

// ----- rtl/tot_match.sv -----
`timescale 1ns / 1ps

module tot_match (
   input  logic                       clock,
   input  logic                       start,
   input  logic                       cmp_en,
   input  logic [tot_pkg::IDX_W-1:0]  cmp_idx,
   input  logic [tot_pkg::KEY_W-1:0]  cmp_key,
   input  logic [tot_pkg::NODE_W-1:0] cmp_holder,
   input  logic                       cmp_live,
   input  logic [tot_pkg::KEY_W-1:0]  req_key,
   output tot_pkg::tot_scan_type      scan_ff
);
   import tot_pkg::*;

   tot_scan_type scan_in;
   logic         key_eq;

   // One wide compare, reused for every slot of the pass.
   assign key_eq = (cmp_key == req_key);

   always_comb begin
      scan_in = scan_ff;
      if (start) begin
         scan_in = '0;
      end else if (cmp_en) begin
         // Keep the first hit and the first free slot.
         if (cmp_live && key_eq && !scan_ff.hit) begin
            scan_in.hit        = 1'b1;
            scan_in.hit_idx    = cmp_idx;
            scan_in.hit_holder = cmp_holder;
         end
         if (!cmp_live && !scan_ff.free_found) begin
            scan_in.free_found = 1'b1;
            scan_in.free_idx   = cmp_idx;
         end
      end
   end

   always_ff @(posedge clock) begin
      scan_ff <= scan_in;
   end

endmodule

// ----- rtl/token_ownership_table.sv -----
`timescale 1ns / 1ps

// Channel   Dir  Fields                                   Handshake
// req_chan  in   operation, key_high, key_low, node_id    valid/ready
// rsp_chan  out  status, holder, token_count              valid/ready
//
// Each item runs in order through the accepting cycle, a pass that reads one slot a
// cycle through the single compare unit, a drain of the read and compare registers,
// a decide-and-write-back step and the load of the output register. A zero key
// skips the pass and goes from accept straight to loading the output register.
// req_chan is ready only while idle, so a result held by a full output register
// stalls it. Synchronous reset clears all live bits and the count.
module token_ownership_table (
   input logic        clock,
   input logic        reset,
   tot_req_if.sink    req_chan,
   tot_rsp_if.source  rsp_chan
);
   import tot_pkg::*;

   tot_state_type        state_ff, state_in;
   tot_op_type           op_ff, op_in;
   logic [KEY_W-1:0]     key_ff, key_in;
   logic [NODE_W-1:0]    node_ff, node_in;
   logic [CNT_W-1:0]     issue_cnt_ff, issue_cnt_in;
   logic                 rd_pend_ff, rd_pend_in;
   logic [IDX_W-1:0]     rd_idx_ff, rd_idx_in;
   logic [CNT_W-1:0]     live_count_ff, live_count_in;
   tot_status_type       res_status_ff, res_status_in;
   logic [NODE_W-1:0]    res_holder_ff, res_holder_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   tot_status_type       rsp_status_ff, rsp_status_in;
   logic [NODE_W-1:0]    rsp_holder_ff, rsp_holder_in;
   logic [TOKEN_W-1:0]   rsp_count_ff, rsp_count_in;

   logic                 scan_start;
   logic                 rsp_free;
   logic [KEY_W-1:0]     req_key;
   logic [CNT_W+TOKEN_W-1:0] count_ext;
   tot_wr_type           wr;
   tot_scan_type         scan;
   logic [KEY_W-1:0]     rd_key;
   logic [NODE_W-1:0]    rd_holder;
   logic                 rd_live;

   tot_store u_store (
      .clock        (clock),
      .reset        (reset),
      .rd_addr      (issue_cnt_ff[IDX_W-1:0]),
      .wr           (wr),
      .rd_key_ff    (rd_key),
      .rd_holder_ff (rd_holder),
      .rd_live_ff   (rd_live)
   );

   tot_match u_match (
      .clock      (clock),
      .start      (scan_start),
      .cmp_en     (rd_pend_ff),
      .cmp_idx    (rd_idx_ff),
      .cmp_key    (rd_key),
      .cmp_holder (rd_holder),
      .cmp_live   (rd_live),
      .req_key    (key_ff),
      .scan_ff    (scan)
   );

   assign req_key   = {req_chan.key_high, req_chan.key_low};
   assign rsp_free  = !rsp_valid_ff || rsp_chan.ready;
   // Token count reports the full live count.
   assign count_ext = {{TOKEN_W{1'b0}}, live_count_ff};

   assign req_chan.ready       = (state_ff == S_IDLE);
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.status      = rsp_status_ff;
   assign rsp_chan.holder      = rsp_holder_ff;
   assign rsp_chan.token_count = rsp_count_ff;

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      node_in       = node_ff;
      issue_cnt_in  = issue_cnt_ff;
      rd_pend_in    = rd_pend_ff;
      rd_idx_in     = rd_idx_ff;
      live_count_in = live_count_ff;
      res_status_in = res_status_ff;
      res_holder_in = res_holder_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_holder_in = rsp_holder_ff;
      rsp_count_in  = rsp_count_ff;
      scan_start    = 1'b0;
      wr            = '0;
      wr.key        = key_ff;
      wr.holder     = node_ff;

      // Drop the output item once it is taken.
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               op_in   = tot_op_type'(req_chan.operation);
               key_in  = req_key;
               node_in = req_chan.node_id;
               if (req_key == '0) begin
                  // Zero key: answer invalid without touching the table.
                  res_status_in = ST_INVALID;
                  res_holder_in = '0;
                  state_in      = S_RESP;
               end else begin
                  issue_cnt_in = '0;
                  rd_pend_in   = 1'b0;
                  scan_start   = 1'b1;
                  state_in     = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            // Issue one slot read a cycle; each slot is compared in the cycle after its read.
            if (issue_cnt_ff != CNT_W'(ENTRIES)) begin
               issue_cnt_in = issue_cnt_ff + CNT_W'(1);
               rd_pend_in   = 1'b1;
               rd_idx_in    = issue_cnt_ff[IDX_W-1:0];
            end else begin
               rd_pend_in = 1'b0;
               if (!rd_pend_ff) begin
                  state_in = S_DECIDE;
               end
            end
         end
         S_DECIDE: begin
            res_status_in = ST_OK;
            res_holder_in = '0;
            unique case (op_ff)
               OP_ACQUIRE: begin
                  if (scan.hit) begin
                     // A live slot always has a real holder.
                     if (scan.hit_holder != node_ff) begin
                        res_status_in = ST_OTHER;
                     end
                  end else if (scan.free_found) begin
                     wr.en         = 1'b1;
                     wr.addr       = scan.free_idx;
                     wr.live       = 1'b1;
                     live_count_in = live_count_ff + CNT_W'(1);
                  end else begin
                     res_status_in = ST_FULL;
                  end
               end
               OP_QUERY: begin
                  if (scan.hit) begin
                     res_holder_in = scan.hit_holder;
                  end else begin
                     res_status_in = ST_NOTOKEN;
                  end
               end
               OP_RELEASE: begin
                  if (!scan.hit) begin
                     res_status_in = ST_NOTOKEN;
                  end else if (scan.hit_holder != node_ff) begin
                     res_status_in = ST_NOTHOLDER;
                  end else begin
                     wr.en         = 1'b1;
                     wr.addr       = scan.hit_idx;
                     wr.live       = 1'b0;
                     live_count_in = live_count_ff - CNT_W'(1);
                  end
               end
               OP_FORCE: begin
                  // Absent key: nothing to free, still ok.
                  if (scan.hit) begin
                     wr.en         = 1'b1;
                     wr.addr       = scan.hit_idx;
                     wr.live       = 1'b0;
                     live_count_in = live_count_ff - CNT_W'(1);
                  end
               end
            endcase
            state_in = S_RESP;
         end
         S_RESP: begin
            // Hold until the output register is free, then load it.
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_holder_in = res_holder_ff;
               rsp_count_in  = count_ext[TOKEN_W-1:0];
               state_in      = S_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         live_count_ff <= '0;
         rd_pend_ff    <= 1'b0;
         issue_cnt_ff  <= '0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         live_count_ff <= live_count_in;
         rd_pend_ff    <= rd_pend_in;
         issue_cnt_ff  <= issue_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      key_ff        <= key_in;
      node_ff       <= node_in;
      rd_idx_ff     <= rd_idx_in;
      res_status_ff <= res_status_in;
      res_holder_ff <= res_holder_in;
      rsp_status_ff <= rsp_status_in;
      rsp_holder_ff <= rsp_holder_in;
      rsp_count_ff  <= rsp_count_in;
   end

endmodule
